/* src/sorted_insertion_list_macros.svh */
// Assertion macros used by the RTL of the sorted insertion list.
`ifndef SORTED_INSERTION_LIST_MACROS_SVH
`define SORTED_INSERTION_LIST_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/sil_pkg.sv */
`timescale 1ns / 1ps

package sil_pkg;

    localparam int unsigned DefaultDepth = 32;
    localparam int unsigned FieldWidth   = 16;

    typedef enum logic [1:0] {
        CMD_INSERT    = 2'd0,
        CMD_READ_ASC  = 2'd1,
        CMD_READ_DESC = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_READ     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_insert;
        logic load_result;
        logic read_step;
        logic desc;
        logic read_start;
    } t_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
        logic read_last;
    } t_stat;

endpackage

/* src/sorted_insertion_list.sv */
`timescale 1ns / 1ps
// Sorted insertion list: keeps up to DEPTH entries in ascending level count.
// Input channel s_axis: tdata carries entry_id, level_count, name_ref from the
// lowest bit up; tuser carries the command (insert, read ascending, read
// descending; the fourth code is ignored).
// Output channel m_axis: tdata carries out_id, out_levels, out_name_ref;
// tuser carries the status; tlast marks the final result of a command.
// An insert first registers the transaction, then updates the cell chain, in
// which every slot compares its key and shifts in parallel, while the result
// register is loaded. An insert into a full list is dropped with status full.
// A read gives one result per stored entry; the result register is loaded
// from the cell array for each entry once the one before is taken; an empty
// list gives a single empty result. Only one command is in flight at a time,
// and a new transaction is accepted once the last result has been taken.
// Reset empties the list at once. While the receiver stalls the result holds.
module sorted_insertion_list import sil_pkg::*; #(
    parameter int unsigned DEPTH = DefaultDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // entry_id, level_count, name_ref
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_id, out_levels, out_name_ref
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast
);

    t_ctrl      w_ctrl;
    t_stat      w_stat;
    logic [1:0] w_status;

    sil_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (t_cmd'(s_axis_tuser)),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    sil_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_cmd          (s_axis_tuser),
        .i_entry_id     (s_axis_tdata[15:0]),
        .i_level_count  (s_axis_tdata[31:16]),
        .i_name_ref     (s_axis_tdata[47:32]),
        .o_stat         (w_stat),
        .o_status       (w_status),
        .o_out_id       (m_axis_tdata[15:0]),
        .o_out_levels   (m_axis_tdata[31:16]),
        .o_out_name_ref (m_axis_tdata[47:32]),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tuser = w_status;

endmodule

/* src/sil_ctrl.sv */
`timescale 1ns / 1ps
`include "sorted_insertion_list_macros.svh"

module sil_ctrl import sil_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_cmd   i_in_cmd,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output t_ctrl  o_ctrl
);

    t_state r_state, n_state;
    logic   r_desc, n_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_desc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_desc  <= n_desc;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_desc      = r_desc;
        o_ctrl      = '0;
        o_ctrl.desc = r_desc;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load_in = 1'b1;
                    unique case (i_in_cmd)
                        CMD_INSERT: n_state = S_INSERT;
                        CMD_READ_ASC, CMD_READ_DESC: begin
                            n_desc            = (i_in_cmd == CMD_READ_DESC);
                            o_ctrl.desc       = n_desc;
                            o_ctrl.read_start = 1'b1;
                            n_state           = S_READ;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INSERT: begin
                o_ctrl.do_insert   = 1'b1;
                o_ctrl.load_result = 1'b1;
                n_state            = S_OUT;
            end
            S_READ: begin
                o_ctrl.load_result = 1'b1;
                n_state            = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.read_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctrl.read_step = 1'b1;
                        n_state          = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `SIL_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `SIL_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `SIL_ASSERT_NEXT(a_insert_out, i_clk, i_rst_n, r_state == S_INSERT, o_out_valid)

endmodule

/* src/sil_datapath.sv */
`timescale 1ns / 1ps

module sil_datapath import sil_pkg::*; #(
    parameter int unsigned DEPTH = DefaultDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    input  logic [1:0]            i_cmd,
    input  logic [FieldWidth-1:0] i_entry_id,
    input  logic [FieldWidth-1:0] i_level_count,
    input  logic [FieldWidth-1:0] i_name_ref,
    output t_stat                 o_stat,
    output logic [1:0]            o_status,
    output logic [FieldWidth-1:0] o_out_id,
    output logic [FieldWidth-1:0] o_out_levels,
    output logic [FieldWidth-1:0] o_out_name_ref,
    output logic                  o_last
);

    localparam int unsigned IdxW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic [FieldWidth-1:0] r_key [DEPTH];
    logic [FieldWidth-1:0] r_id  [DEPTH];
    logic [FieldWidth-1:0] r_nm  [DEPTH];
    logic [CntW-1:0]       r_occ;
    logic [FieldWidth-1:0] r_in_id, r_in_key, r_in_nm;
    logic [IdxW-1:0]       r_pos;
    logic [CntW-1:0]       r_left;
    logic [DEPTH-1:0]      w_le;
    logic [IdxW-1:0]       w_rd_idx;
    logic                  w_full;

    assign w_full = (r_occ == CntW'(DEPTH));

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_le[i] = (CntW'(i) < r_occ) && (r_key[i] <= r_in_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_ctrl.do_insert && !w_full) begin
            r_occ <= r_occ + CntW'(1);
        end
    end

    // Each cell keeps its entry, takes its left neighbour's, or takes the new one.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.do_insert && !w_full) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!w_le[i]) begin
                    if (i > 0 && !w_le[(i > 0) ? i - 1 : 0]) begin
                        r_key[i] <= r_key[(i > 0) ? i - 1 : 0];
                        r_id[i]  <= r_id[(i > 0) ? i - 1 : 0];
                        r_nm[i]  <= r_nm[(i > 0) ? i - 1 : 0];
                    end else begin
                        r_key[i] <= r_in_key;
                        r_id[i]  <= r_in_id;
                        r_nm[i]  <= r_in_nm;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_in_id  <= i_entry_id;
            r_in_key <= i_level_count;
            r_in_nm  <= i_name_ref;
        end
        if (i_ctrl.read_start) begin
            r_left <= r_occ;
            r_pos  <= i_ctrl.desc ? IdxW'(r_occ - CntW'(1)) : '0;
        end else if (i_ctrl.read_step) begin
            r_left <= r_left - CntW'(1);
            r_pos  <= i_ctrl.desc ? r_pos - IdxW'(1) : r_pos + IdxW'(1);
        end
    end

    assign w_rd_idx = r_pos;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_result) begin
            if (i_ctrl.do_insert) begin
                o_status       <= w_full ? ST_FULL : ST_INSERTED;
                o_out_id       <= '0;
                o_out_levels   <= '0;
                o_out_name_ref <= '0;
                o_last         <= 1'b1;
            end else if (r_left == '0) begin
                o_status       <= ST_EMPTY;
                o_out_id       <= '0;
                o_out_levels   <= '0;
                o_out_name_ref <= '0;
                o_last         <= 1'b1;
            end else begin
                o_status       <= ST_READ;
                o_out_id       <= r_id[w_rd_idx];
                o_out_levels   <= r_key[w_rd_idx];
                o_out_name_ref <= r_nm[w_rd_idx];
                o_last         <= (r_left == CntW'(1));
            end
        end
    end

    assign o_stat.full      = w_full;
    assign o_stat.empty     = (r_occ == '0) && (i_cmd != 2'd0);
    assign o_stat.read_last = o_last;

endmodule
